// ===== rtl/gam_pkg.sv =====
package gam_pkg;

   // request modes
   localparam logic [1:0] MODE_ROW     = 2'd0;
   localparam logic [1:0] MODE_RATE    = 2'd1;
   localparam logic [1:0] MODE_RATE_DT = 2'd2;
   localparam logic [1:0] MODE_MEASURE = 2'd3;

   // register indexes
   localparam logic [2:0] CSR_GAIN_ATT = 3'd0;
   localparam logic [2:0] CSR_GAIN_RATE = 3'd1;
   localparam logic [2:0] CSR_J_00_01  = 3'd2;
   localparam logic [2:0] CSR_J_02_10  = 3'd3;
   localparam logic [2:0] CSR_J_11_12  = 3'd4;
   localparam logic [2:0] CSR_J_20_21  = 3'd5;
   localparam logic [2:0] CSR_J_22     = 3'd6;

   localparam logic [31:0] Q_ONE = 32'h0001_0000;

   // scratch memory map
   localparam int RAM_DEPTH = 64;
   localparam int A_RD   = 0;
   localparam int A_WD   = 9;
   localparam int A_WDD  = 12;
   localparam int A_Q    = 15;
   localparam int A_V    = 19;
   localparam int A_R    = 22;
   localparam int A_P    = 31;
   localparam int A_PWD  = 40;
   localparam int A_PWDD = 43;
   localparam int A_ER   = 46;
   localparam int A_EW   = 49;
   localparam int A_JW   = 52;
   localparam int A_T3   = 55;
   localparam int A_CWP  = 58;
   localparam int A_T4   = 22;  // R is dead once P is formed
   localparam int A_T5   = 25;

   // operand sources above the memory range
   localparam int SRC_KR  = 64;
   localparam int SRC_KW  = 65;
   localparam int SRC_J   = 66;
   localparam int SRC_ONE = 75;

   typedef enum logic [1:0] {
      POST_NONE   = 2'd0,
      POST_DOUBLE = 2'd1,
      POST_HALVE  = 2'd2
   } post_type;

   typedef struct packed {
      logic [6:0] src_a;
      logic [6:0] src_b;
      logic       neg;
      logic       last;
      post_type   post;
      logic       to_out;
      logic [5:0] dest;
   } uop_type;

   typedef struct packed {
      logic     mul_en;
      logic     acc_en;
      logic     first;
      logic     neg;
      post_type post;
   } mac_ctl_type;

   localparam int UOP_COUNT = 135;

   typedef uop_type [UOP_COUNT-1:0] ucode_type;

   function automatic uop_type mk_op(input int a, input int b, input logic neg,
                                     input logic last, input post_type post,
                                     input int dest, input logic to_out);
      uop_type u;
      u.src_a  = 7'(a);
      u.src_b  = 7'(b);
      u.neg    = neg;
      u.last   = last;
      u.post   = post;
      u.to_out = to_out;
      u.dest   = 6'(dest);
      return u;
   endfunction

   function automatic ucode_type build_ucode();
      ucode_type u;
      int n;
      int p;
      int q;
      u = '0;
      n = 0;
      // diagonal of R: sums of squares
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 4; k++) begin
            u[n] = mk_op(A_Q + k, A_Q + k, !(k == 0 || k == i + 1), k == 3, POST_NONE,
                         A_R + 4 * i, 1'b0);
            n++;
         end
      end
      // off-diagonal of R, doubled
      u[n] = mk_op(A_Q+1, A_Q+2, 1'b0, 1'b0, POST_DOUBLE, A_R+1, 1'b0); n++;
      u[n] = mk_op(A_Q+0, A_Q+3, 1'b1, 1'b1, POST_DOUBLE, A_R+1, 1'b0); n++;
      u[n] = mk_op(A_Q+0, A_Q+2, 1'b0, 1'b0, POST_DOUBLE, A_R+2, 1'b0); n++;
      u[n] = mk_op(A_Q+1, A_Q+3, 1'b0, 1'b1, POST_DOUBLE, A_R+2, 1'b0); n++;
      u[n] = mk_op(A_Q+1, A_Q+2, 1'b0, 1'b0, POST_DOUBLE, A_R+3, 1'b0); n++;
      u[n] = mk_op(A_Q+0, A_Q+3, 1'b0, 1'b1, POST_DOUBLE, A_R+3, 1'b0); n++;
      u[n] = mk_op(A_Q+2, A_Q+3, 1'b0, 1'b0, POST_DOUBLE, A_R+5, 1'b0); n++;
      u[n] = mk_op(A_Q+0, A_Q+1, 1'b1, 1'b1, POST_DOUBLE, A_R+5, 1'b0); n++;
      u[n] = mk_op(A_Q+1, A_Q+3, 1'b0, 1'b0, POST_DOUBLE, A_R+6, 1'b0); n++;
      u[n] = mk_op(A_Q+0, A_Q+2, 1'b1, 1'b1, POST_DOUBLE, A_R+6, 1'b0); n++;
      u[n] = mk_op(A_Q+0, A_Q+1, 1'b0, 1'b0, POST_DOUBLE, A_R+7, 1'b0); n++;
      u[n] = mk_op(A_Q+2, A_Q+3, 1'b0, 1'b1, POST_DOUBLE, A_R+7, 1'b0); n++;
      // P = R^T Rd
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            for (int k = 0; k < 3; k++) begin
               u[n] = mk_op(A_R + 3*k + i, A_RD + 3*k + j, 1'b0, k == 2, POST_NONE,
                            A_P + 3*i + j, 1'b0);
               n++;
            end
      // P wd and P wdd
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++) begin
            u[n] = mk_op(A_P + 3*i + k, A_WD + k, 1'b0, k == 2, POST_NONE, A_PWD + i, 1'b0);
            n++;
         end
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++) begin
            u[n] = mk_op(A_P + 3*i + k, A_WDD + k, 1'b0, k == 2, POST_NONE, A_PWDD + i,
                         1'b0);
            n++;
         end
      // eR, halved after the difference
      u[n] = mk_op(A_P+5, SRC_ONE, 1'b0, 1'b0, POST_HALVE, A_ER+0, 1'b0); n++;
      u[n] = mk_op(A_P+7, SRC_ONE, 1'b1, 1'b1, POST_HALVE, A_ER+0, 1'b0); n++;
      u[n] = mk_op(A_P+6, SRC_ONE, 1'b0, 1'b0, POST_HALVE, A_ER+1, 1'b0); n++;
      u[n] = mk_op(A_P+2, SRC_ONE, 1'b1, 1'b1, POST_HALVE, A_ER+1, 1'b0); n++;
      u[n] = mk_op(A_P+1, SRC_ONE, 1'b0, 1'b0, POST_HALVE, A_ER+2, 1'b0); n++;
      u[n] = mk_op(A_P+3, SRC_ONE, 1'b1, 1'b1, POST_HALVE, A_ER+2, 1'b0); n++;
      // eW
      for (int i = 0; i < 3; i++) begin
         u[n] = mk_op(A_V + i, SRC_ONE, 1'b0, 1'b0, POST_NONE, A_EW + i, 1'b0); n++;
         u[n] = mk_op(A_PWD + i, SRC_ONE, 1'b1, 1'b1, POST_NONE, A_EW + i, 1'b0); n++;
      end
      // J w
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++) begin
            u[n] = mk_op(SRC_J + 3*i + k, A_V + k, 1'b0, k == 2, POST_NONE, A_JW + i, 1'b0);
            n++;
         end
      // w x (J w)
      for (int i = 0; i < 3; i++) begin
         p = (i == 2) ? 0 : i + 1;
         q = (i == 0) ? 2 : i - 1;
         u[n] = mk_op(A_V + p, A_JW + q, 1'b0, 1'b0, POST_NONE, A_T3 + i, 1'b0); n++;
         u[n] = mk_op(A_V + q, A_JW + p, 1'b1, 1'b1, POST_NONE, A_T3 + i, 1'b0); n++;
      end
      // w x (P wd)
      for (int i = 0; i < 3; i++) begin
         p = (i == 2) ? 0 : i + 1;
         q = (i == 0) ? 2 : i - 1;
         u[n] = mk_op(A_V + p, A_PWD + q, 1'b0, 1'b0, POST_NONE, A_CWP + i, 1'b0); n++;
         u[n] = mk_op(A_V + q, A_PWD + p, 1'b1, 1'b1, POST_NONE, A_CWP + i, 1'b0); n++;
      end
      // J (w x P wd) and J P wdd
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++) begin
            u[n] = mk_op(SRC_J + 3*i + k, A_CWP + k, 1'b0, k == 2, POST_NONE, A_T4 + i,
                         1'b0);
            n++;
         end
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++) begin
            u[n] = mk_op(SRC_J + 3*i + k, A_PWDD + k, 1'b0, k == 2, POST_NONE, A_T5 + i,
                         1'b0);
            n++;
         end
      // moment
      for (int i = 0; i < 3; i++) begin
         u[n] = mk_op(SRC_KR, A_ER + i, 1'b1, 1'b0, POST_NONE, i, 1'b1); n++;
         u[n] = mk_op(SRC_KW, A_EW + i, 1'b1, 1'b0, POST_NONE, i, 1'b1); n++;
         u[n] = mk_op(A_T3 + i, SRC_ONE, 1'b0, 1'b0, POST_NONE, i, 1'b1); n++;
         u[n] = mk_op(A_T4 + i, SRC_ONE, 1'b1, 1'b0, POST_NONE, i, 1'b1); n++;
         u[n] = mk_op(A_T5 + i, SRC_ONE, 1'b0, 1'b1, POST_NONE, i, 1'b1); n++;
      end
      return u;
   endfunction

   localparam ucode_type UCODE = build_ucode();

endpackage

// ===== rtl/gam_if.sv =====
interface gam_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [1:0]         row;
   logic signed [31:0] quat_w;
   logic signed [31:0] quat_x;
   logic signed [31:0] quat_y;
   logic signed [31:0] quat_z;
   logic signed [31:0] vec_x;
   logic signed [31:0] vec_y;
   logic signed [31:0] vec_z;

   modport source (output valid, mode, row, quat_w, quat_x, quat_y, quat_z,
                   vec_x, vec_y, vec_z, input ready);
   modport sink (input valid, mode, row, quat_w, quat_x, quat_y, quat_z,
                 vec_x, vec_y, vec_z, output ready);
endinterface

interface gam_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] moment_x;
   logic signed [31:0] moment_y;
   logic signed [31:0] moment_z;

   modport source (output valid, moment_x, moment_y, moment_z, input ready);
   modport sink (input valid, moment_x, moment_y, moment_z, output ready);
endinterface

// ===== rtl/gam_ram.sv =====
module gam_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end
endmodule

// ===== rtl/gam_mac.sv =====
module gam_mac (
   input  logic                 clock,
   input  gam_pkg::mac_ctl_type ctl,
   input  logic signed [31:0]   op_a,
   input  logic signed [31:0]   op_b,
   output logic signed [31:0]   result
);
   logic signed [63:0] product_ff;
   logic signed [51:0] acc_ff;
   logic signed [51:0] acc_in;
   logic signed [51:0] acc_base;
   logic signed [51:0] term;
   logic signed [52:0] scaled;

   // floor(a*b / 2^16)
   assign term     = 52'(product_ff[63:16]) | {{4{product_ff[63]}}, 48'd0};
   assign acc_base = ctl.first ? '0 : acc_ff;
   assign acc_in   = ctl.neg ? acc_base - term : acc_base + term;

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         product_ff <= op_a * op_b;
      end
      if (ctl.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      case (ctl.post)
         gam_pkg::POST_DOUBLE: scaled = {acc_ff, 1'b0};
         gam_pkg::POST_HALVE:  scaled = {{2{acc_ff[51]}}, acc_ff[51:1]};
         default:              scaled = {acc_ff[51], acc_ff};
      endcase
      if (!scaled[52] && (|scaled[51:31])) begin
         result = 32'sh7FFF_FFFF;
      end else if (scaled[52] && !(&scaled[51:31])) begin
         result = 32'sh8000_0000;
      end else begin
         result = scaled[31:0];
      end
   end
endmodule

// ===== rtl/geometric_attitude_moment_core.sv =====
// Geometric attitude controller, Q16.16 fixed point.
// Requests arrive on req_if (valid/ready). Modes 0..2 load one row of the
// desired rotation, the desired rate or its derivative from the vector
// words and give no response. Mode 3 carries the quaternion and body rate
// and gives one response on rsp_if with the three saturated moment
// components. A measurement stores its seven request words, then runs
// 135 multiply-accumulate steps (read, multiply, accumulate) and one
// write-back per result word (48 of them). All of it runs through one
// shared 32x32 multiplier and accumulator fed from a 64-word scratch
// memory, so req_if.ready is low while a measurement is in progress.
// Gains and inertia sit on the csr_ port; write them only while idle.
// After reset a clearing pass zeroes the stored setpoint; req_if.ready
// stays low meanwhile. Register writes are taken at any time.
// The response sits in an output register: a stalled receiver does not stop
// the next request being taken; only the moment write-backs of the
// following measurement wait until the earlier response has gone.
module geometric_attitude_moment_core (
   input  logic        clock,
   input  logic        reset,
   gam_req_if.sink     req_if,
   gam_rsp_if.source   rsp_if,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_LOAD  = 7'b0000100,
      ST_RD    = 7'b0001000,
      ST_MUL   = 7'b0010000,
      ST_ACC   = 7'b0100000,
      ST_WB    = 7'b1000000
   } state_type;

   localparam int AW = $clog2(gam_pkg::RAM_DEPTH);
   localparam logic [7:0] PC_LAST = 8'(gam_pkg::UOP_COUNT - 1);

   state_type state_ff, state_in;
   logic [7:0] pc_ff, pc_in;
   logic first_ff, first_in;
   logic [3:0] clr_cnt_ff;
   logic [2:0] ld_cnt_ff, ld_cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [1:0] mode_ff;
   logic [1:0] row_ff;
   logic [31:0] word_ff [7];
   logic [31:0] moment_ff [3];

   logic [30:0] kr_ff;
   logic [30:0] kw_ff;
   logic [31:0] j_ff [9];

   gam_pkg::uop_type cur_uop;
   gam_pkg::mac_ctl_type mac_ctl;
   logic signed [31:0] op_a, op_b, mac_result;

   logic ram_we;
   logic [AW-1:0] ram_waddr;
   logic [31:0] ram_wdata, rdata_a, rdata_b;

   logic req_fire, wb_go, ld_done;
   logic [AW-1:0] ld_base;
   logic [2:0] ld_word;

   assign cur_uop  = gam_pkg::UCODE[pc_ff];
   assign req_fire = req_if.valid && req_if.ready;
   assign wb_go    = !(cur_uop.to_out && rsp_valid_ff && !rsp_if.ready);
   assign ld_done  = (mode_ff == gam_pkg::MODE_MEASURE) ? (ld_cnt_ff == 3'd6)
                                                        : (ld_cnt_ff == 3'd2);

   assign req_if.ready    = (state_ff == ST_IDLE);
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.moment_x = moment_ff[0];
   assign rsp_if.moment_y = moment_ff[1];
   assign rsp_if.moment_z = moment_ff[2];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kr_ff <= '0;
         kw_ff <= '0;
         for (int i = 0; i < 9; i++) j_ff[i] <= '0;
      end else if (csr_we) begin
         case (csr_index)
            gam_pkg::CSR_GAIN_ATT:  kr_ff <= csr_wdata[30:0];
            gam_pkg::CSR_GAIN_RATE: kw_ff <= csr_wdata[30:0];
            gam_pkg::CSR_J_00_01: begin
               j_ff[0] <= csr_wdata[31:0];
               j_ff[1] <= csr_wdata[63:32];
            end
            gam_pkg::CSR_J_02_10: begin
               j_ff[2] <= csr_wdata[31:0];
               j_ff[3] <= csr_wdata[63:32];
            end
            gam_pkg::CSR_J_11_12: begin
               j_ff[4] <= csr_wdata[31:0];
               j_ff[5] <= csr_wdata[63:32];
            end
            gam_pkg::CSR_J_20_21: begin
               j_ff[6] <= csr_wdata[31:0];
               j_ff[7] <= csr_wdata[63:32];
            end
            gam_pkg::CSR_J_22: j_ff[8] <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   function automatic logic [31:0] operand(input logic [6:0] code, input logic [31:0] ram_word);
      logic [31:0] v;
      v = ram_word;
      if (code == 7'(gam_pkg::SRC_KR)) v = {1'b0, kr_ff};
      if (code == 7'(gam_pkg::SRC_KW)) v = {1'b0, kw_ff};
      if (code == 7'(gam_pkg::SRC_ONE)) v = gam_pkg::Q_ONE;
      for (int i = 0; i < 9; i++) begin
         if (code == 7'(gam_pkg::SRC_J + i)) v = j_ff[i];
      end
      return v;
   endfunction

   always_comb begin
      op_a = operand(cur_uop.src_a, rdata_a);
      op_b = operand(cur_uop.src_b, rdata_b);
   end

   always_comb begin
      mac_ctl.mul_en = (state_ff == ST_MUL);
      mac_ctl.acc_en = (state_ff == ST_ACC);
      mac_ctl.first  = first_ff;
      mac_ctl.neg    = cur_uop.neg;
      mac_ctl.post   = cur_uop.post;
   end

   gam_mac u_mac (
      .clock  (clock),
      .ctl    (mac_ctl),
      .op_a   (op_a),
      .op_b   (op_b),
      .result (mac_result)
   );

   // load addressing
   always_comb begin
      case (mode_ff)
         gam_pkg::MODE_ROW:     ld_base = AW'({row_ff, 1'b0}) + AW'(row_ff);
         gam_pkg::MODE_RATE:    ld_base = AW'(gam_pkg::A_WD);
         gam_pkg::MODE_RATE_DT: ld_base = AW'(gam_pkg::A_WDD);
         default:               ld_base = AW'(gam_pkg::A_Q);
      endcase
      ld_word = (mode_ff == gam_pkg::MODE_MEASURE) ? ld_cnt_ff : ld_cnt_ff + 3'd4;
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = cur_uop.dest;
      ram_wdata = mac_result;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(clr_cnt_ff);
            ram_wdata = '0;
         end
         ST_LOAD: begin
            ram_we    = 1'b1;
            ram_waddr = ld_base + AW'(ld_cnt_ff);
            ram_wdata = word_ff[ld_word];
         end
         ST_WB: ram_we = wb_go && !cur_uop.to_out;
         default: ;
      endcase
   end

   gam_ram #(.WIDTH(32), .DEPTH(gam_pkg::RAM_DEPTH)) u_ram (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .raddr_a (cur_uop.src_a[AW-1:0]),
      .raddr_b (cur_uop.src_b[AW-1:0]),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      first_in     = first_ff;
      ld_cnt_in    = ld_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      case (state_ff)
         ST_CLEAR: if (clr_cnt_ff == 4'hF) state_in = ST_IDLE;
         ST_IDLE: begin
            ld_cnt_in = '0;
            if (req_fire && !(req_if.mode == gam_pkg::MODE_ROW && req_if.row == 2'd3)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            ld_cnt_in = ld_cnt_ff + 3'd1;
            if (ld_done) begin
               pc_in    = '0;
               first_in = 1'b1;
               state_in = (mode_ff == gam_pkg::MODE_MEASURE) ? ST_RD : ST_IDLE;
            end
         end
         ST_RD:  state_in = ST_MUL;
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            first_in = cur_uop.last;
            if (cur_uop.last) begin
               state_in = ST_WB;
            end else begin
               pc_in    = pc_ff + 8'd1;
               state_in = ST_RD;
            end
         end
         ST_WB: begin
            if (wb_go) begin
               if (pc_ff == PC_LAST) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  pc_in    = pc_ff + 8'd1;
                  state_in = ST_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pc_ff        <= '0;
         first_ff     <= 1'b1;
         clr_cnt_ff   <= '0;
         ld_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         first_ff     <= first_in;
         clr_cnt_ff   <= clr_cnt_ff + 4'd1;
         ld_cnt_ff    <= ld_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff    <= req_if.mode;
         row_ff     <= req_if.row;
         word_ff[0] <= req_if.quat_w;
         word_ff[1] <= req_if.quat_x;
         word_ff[2] <= req_if.quat_y;
         word_ff[3] <= req_if.quat_z;
         word_ff[4] <= req_if.vec_x;
         word_ff[5] <= req_if.vec_y;
         word_ff[6] <= req_if.vec_z;
      end
      if (state_ff == ST_WB && wb_go && cur_uop.to_out) begin
         moment_ff[cur_uop.dest[1:0]] <= mac_result;
      end
   end

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD) |-> (pc_ff <= PC_LAST))
      else $error("microcode counter out of range");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_if.ready)
      else $error("request taken during clearing pass");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_WB && $past(pc_ff) == PC_LAST))
      else $error("response raised outside final write-back");

   a_wb_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WB) |-> cur_uop.last)
      else $error("write-back on a step that does not end a sum");
endmodule
